FILE: hdl/xmmd_pkg.sv
// Constants and types shared by the MMIO MOV decoder.
package xmmd_pkg;

	localparam int unsigned WINDOW_BYTES = 15;
	localparam int unsigned IDX_W        = $clog2(WINDOW_BYTES);
	localparam int unsigned POS_W        = $clog2(WINDOW_BYTES + 1);
	localparam int unsigned LEN_W        = POS_W + 1;

	localparam logic [7:0] PFX_OPSIZE   = 8'h66;
	localparam logic [3:0] PFX_REX_HI   = 4'h4;
	localparam logic [7:0] OP_MOV_ST8   = 8'h88;
	localparam logic [7:0] OP_MOV_ST    = 8'h89;
	localparam logic [7:0] OP_MOV_LD8   = 8'h8A;
	localparam logic [7:0] OP_MOV_LD    = 8'h8B;

	localparam logic [1:0] MOD_NODISP   = 2'd0;
	localparam logic [1:0] MOD_DISP8    = 2'd1;
	localparam logic [1:0] MOD_DISP32   = 2'd2;
	localparam logic [1:0] MOD_REG      = 2'd3;
	localparam logic [2:0] RM_SIB       = 3'd4;
	localparam logic [2:0] RM_DISP32    = 3'd5;
	localparam logic [2:0] SIB_BASE_D32 = 3'd5;
	localparam logic [3:0] REG_SP       = 4'd4;

	typedef logic [1:0] status_t;
	localparam status_t ST_OK        = 2'd0;
	localparam status_t ST_BAD_OP    = 2'd1;
	localparam status_t ST_BAD_REG   = 2'd2;
	localparam status_t ST_EXHAUSTED = 2'd3;

	typedef struct packed {
		logic             exhausted;
		logic [7:0]       opcode;
		logic [7:0]       modrm;
		logic [7:0]       sib;
		logic [POS_W-1:0] pos;
		logic             rex_w;
		logic             rex_r;
		logic             opsize16;
	} fetch_t;

endpackage

FILE: hdl/x86_mov_mmio_decoder_unit.sv
// Three-stage decoder for MOV instructions that faulted on an MMIO access.

// Decodes one window of up to 15 x86 instruction bytes per beat and returns
// status, direction, access size, register index, upper-half clear and total
// length. One beat is accepted every cycle unless an output stall holds the
// stages. Stage 1 finds the end of the 0x66/REX prefix run, stage 2
// gathers the last REX, the operand-size prefix and the opcode, ModRM and SIB
// bytes, stage 3 checks and sizes the instruction into the output register.
// A stall at the output backs up through the stages without losing a beat.
module x86_mov_mmio_decoder_unit #(
	parameter int unsigned MAX_INSTRUCTION_BYTES = 15
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [63:0] code_bytes_low,
	input  logic [55:0] code_bytes_high,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic        is_write,
	output logic [3:0]  access_size,
	output logic [3:0]  register_index,
	output logic        clear_upper_half,
	output logic [3:0]  instruction_length
);

	localparam int unsigned WB    = xmmd_pkg::WINDOW_BYTES;
	localparam int unsigned IW    = xmmd_pkg::IDX_W;
	localparam int unsigned PW    = xmmd_pkg::POS_W;
	localparam int unsigned LW    = xmmd_pkg::LEN_W;
	localparam int unsigned LIMIT = (MAX_INSTRUCTION_BYTES > WB) ? WB : MAX_INSTRUCTION_BYTES;
	localparam logic [LW-1:0] LIMIT_L = LW'(LIMIT);

	// handshake chain
	logic v_s1, v_s2, v_s3;
	logic adv_s1, adv_s2, adv_s3;

	assign adv_s3   = !v_s3 || out_ready;
	assign adv_s2   = !v_s2 || adv_s3;
	assign adv_s1   = !v_s1 || adv_s2;
	assign in_ready = adv_s1;

	// stage 1: prefix run length
	logic [7:0]    win_in [WB];
	logic [7:0]    win_s1 [WB];
	logic [PW-1:0] pos_s1;
	logic          exh_s1;
	logic [PW-1:0] run_len;
	logic          run_on;

	always_comb begin
		for (int i = 0; i < WB; i++) begin
			if (i < 8) begin
				win_in[i] = code_bytes_low[i*8 +: 8];
			end else begin
				win_in[i] = code_bytes_high[(i-8)*8 +: 8];
			end
		end
	end

	always_comb begin
		run_len = '0;
		run_on  = 1'b1;
		for (int i = 0; i < WB; i++) begin
			if (run_on && (i < LIMIT) && ((win_in[i] == xmmd_pkg::PFX_OPSIZE) ||
			    (win_in[i][7:4] == xmmd_pkg::PFX_REX_HI))) begin
				run_len = run_len + PW'(1);
			end else begin
				run_on = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv_s1) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && in_valid) begin
			win_s1 <= win_in;
			pos_s1 <= run_len;
			exh_s1 <= (run_len == PW'(LIMIT));
		end
	end

	// stage 2: prefix content and byte fetch
	function automatic logic [7:0] pick(input logic [7:0] w [WB], input logic [LW-1:0] idx);
		logic [7:0] r;
		r = 8'h00;
		if (idx < LW'(WB)) begin
			r = w[idx[IW-1:0]];
		end
		return r;
	endfunction

	xmmd_pkg::fetch_t fet, fet_s2;

	always_comb begin
		fet.exhausted = exh_s1;
		fet.pos       = pos_s1;
		fet.rex_w     = 1'b0;
		fet.rex_r     = 1'b0;
		fet.opsize16  = 1'b0;
		for (int i = 0; i < WB; i++) begin
			if (PW'(i) < pos_s1) begin
				if (win_s1[i] == xmmd_pkg::PFX_OPSIZE) begin
					fet.opsize16 = 1'b1;
				end else begin
					// last REX wins
					fet.rex_w = win_s1[i][3];
					fet.rex_r = win_s1[i][2];
				end
			end
		end
		fet.opcode = pick(win_s1, {1'b0, pos_s1});
		fet.modrm  = pick(win_s1, {1'b0, pos_s1} + LW'(1));
		fet.sib    = pick(win_s1, {1'b0, pos_s1} + LW'(2));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && v_s1) begin
			fet_s2 <= fet;
		end
	end

	// stage 3: checks, length and size
	logic [1:0]    md;
	logic [2:0]    rm;
	logic [3:0]    reg_idx;
	logic          op_ok;
	logic          need_sib;
	logic [LW-1:0] pos1;
	logic [2:0]    extra;
	logic [LW-1:0] len;
	logic [3:0]    size;
	logic          wr;
	xmmd_pkg::status_t st;

	always_comb begin
		md       = fet_s2.modrm[7:6];
		rm       = fet_s2.modrm[2:0];
		reg_idx  = {fet_s2.rex_r, fet_s2.modrm[5:3]};
		op_ok    = (fet_s2.opcode == xmmd_pkg::OP_MOV_ST8) ||
		           (fet_s2.opcode == xmmd_pkg::OP_MOV_ST) ||
		           (fet_s2.opcode == xmmd_pkg::OP_MOV_LD8) ||
		           (fet_s2.opcode == xmmd_pkg::OP_MOV_LD);
		need_sib = (md != xmmd_pkg::MOD_REG) && (rm == xmmd_pkg::RM_SIB);
		pos1     = {1'b0, fet_s2.pos} + LW'(1);

		extra = 3'd0;
		if (md == xmmd_pkg::MOD_DISP32 ||
		    (md == xmmd_pkg::MOD_NODISP && rm == xmmd_pkg::RM_DISP32) ||
		    (need_sib && md == xmmd_pkg::MOD_NODISP &&
		     fet_s2.sib[2:0] == xmmd_pkg::SIB_BASE_D32)) begin
			extra = 3'd4;
		end else if (md == xmmd_pkg::MOD_DISP8) begin
			extra = 3'd1;
		end

		len = pos1 + LW'(1) + LW'(need_sib) + LW'(extra);

		if (!fet_s2.opcode[0]) begin
			size = 4'd1;
		end else if (fet_s2.rex_w) begin
			size = 4'd8;
		end else if (fet_s2.opsize16) begin
			size = 4'd2;
		end else begin
			size = 4'd4;
		end
		wr = (fet_s2.opcode == xmmd_pkg::OP_MOV_ST8) || (fet_s2.opcode == xmmd_pkg::OP_MOV_ST);

		if (fet_s2.exhausted) begin
			st = xmmd_pkg::ST_EXHAUSTED;
		end else if (!op_ok) begin
			st = xmmd_pkg::ST_BAD_OP;
		end else if (pos1 >= LIMIT_L) begin
			st = xmmd_pkg::ST_EXHAUSTED;
		end else if (reg_idx == xmmd_pkg::REG_SP) begin
			st = xmmd_pkg::ST_BAD_REG;
		end else if (need_sib && (pos1 + LW'(1) >= LIMIT_L)) begin
			st = xmmd_pkg::ST_EXHAUSTED;
		end else if (len > LIMIT_L) begin
			st = xmmd_pkg::ST_EXHAUSTED;
		end else begin
			st = xmmd_pkg::ST_OK;
		end
	end

	xmmd_pkg::status_t st_s3;
	logic       wr_s3, clr_s3;
	logic [3:0] size_s3, reg_s3, len_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (adv_s3) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s3 && v_s2) begin
			st_s3 <= st;
			if (st == xmmd_pkg::ST_OK) begin
				wr_s3   <= wr;
				size_s3 <= size;
				reg_s3  <= reg_idx;
				clr_s3  <= !wr && (size == 4'd4);
				len_s3  <= len[3:0];
			end else begin
				// error beats carry zero fields
				wr_s3   <= 1'b0;
				size_s3 <= 4'd0;
				reg_s3  <= 4'd0;
				clr_s3  <= 1'b0;
				len_s3  <= 4'd0;
			end
		end
	end

	assign out_valid          = v_s3;
	assign status             = st_s3;
	assign is_write           = wr_s3;
	assign access_size        = size_s3;
	assign register_index     = reg_s3;
	assign clear_upper_half   = clr_s3;
	assign instruction_length = len_s3;

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != xmmd_pkg::ST_OK) |->
		(!is_write && access_size == 4'd0 && register_index == 4'd0 &&
		 !clear_upper_half && instruction_length == 4'd0))
		else $error("error beat with nonzero fields");

	a_ok_len: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == xmmd_pkg::ST_OK) |->
		(instruction_length >= 4'd2 && {1'b0, instruction_length} <= LIMIT_L))
		else $error("decoded length out of window");

	a_ok_size: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == xmmd_pkg::ST_OK) |->
		($onehot(access_size) && register_index != xmmd_pkg::REG_SP))
		else $error("bad size or stack register on ok beat");

	a_clr: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && clear_upper_half) |-> (!is_write && access_size == 4'd4))
		else $error("upper-half clear on non 4-byte read");

endmodule
